>>> rtl/kceg_pkg.sv
// Shared types and helpers for the key change event generator.
// No dependencies.
package kceg_pkg;

    localparam int KEY_W     = 16;
    localparam int KEY_IDX_W = 4;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;

    typedef logic [KEY_W-1:0]     key_vec_t;
    typedef logic [KEY_IDX_W-1:0] key_idx_t;

    // One queued request: keys that went down and keys that came up.
    typedef struct packed {
        key_vec_t press_mask;
        key_vec_t rel_mask;
    } kceg_entry_t;

    // Index of the lowest set bit; zero when none is set.
    function automatic key_idx_t lowest_index(input key_vec_t v);
        key_idx_t idx;
        idx = '0;
        for (int k = KEY_W - 1; k >= 0; k--)
        begin
            if (v[k])
            begin
                idx = KEY_IDX_W'(k);
            end
        end
        return idx;
    endfunction

endpackage

>>> rtl/key_change_event_generator.sv
// Key change event generator, top level.
// Depends on kceg_pkg, kceg_front, kceg_queue, kceg_back.
//
// Input channel: key_state with key_valid/key_stall. Each request is one
// sampled key vector; it is compared with the previously accepted vector.
// Output channel: is_release, key_number, last with event_valid/event_stall.
// One event per changed key among keys 0 to NUM_KEYS-1: presses in
// ascending key order, then releases in ascending order; last marks the
// final event of a sample. A sample with no change yields no event.
// A sample's change masks pass through the queue and the serializer's
// mask registers before its first event reaches the output register. The
// serializer emits one event per cycle unless event_stall holds it; it
// loads each change request from the two-entry queue in a step of its own.
// key_stall rises only when the queue holds two pending change requests.
// event_stall holds the output register; the serializer waits behind it.
// Reset clears the held key vector to all released, empties the queue and
// drops event_valid.
module key_change_event_generator #(
    parameter int NUM_KEYS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  kceg_pkg::key_vec_t  key_state,
    input  logic                key_valid,
    output logic                key_stall,
    output logic                event_valid,
    input  logic                event_stall,
    output logic                is_release,
    output kceg_pkg::key_idx_t  key_number,
    output logic                last
);
    import kceg_pkg::*;

    logic        push;
    kceg_entry_t push_data;
    logic        pop;
    kceg_entry_t head;
    logic        q_full;
    logic        q_empty;

    kceg_front #(
        .NUM_KEYS (NUM_KEYS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_state (key_state),
        .key_valid (key_valid),
        .key_stall (key_stall),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    kceg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    kceg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_empty     (q_empty),
        .pop         (pop),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .is_release  (is_release),
        .key_number  (key_number),
        .last        (last)
    );

endmodule

>>> rtl/kceg_front.sv
// Front end: takes key samples, diffs them against the held vector, queues change masks.
// Depends on kceg_pkg.
module kceg_front #(
    parameter int NUM_KEYS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  kceg_pkg::key_vec_t    key_state,
    input  logic                  key_valid,
    output logic                  key_stall,
    input  logic                  q_full,
    output logic                  push,
    output kceg_pkg::kceg_entry_t push_data
);
    import kceg_pkg::*;

    localparam logic [KEY_W:0] KEY_ONE_HOT = (KEY_W+1)'(1) << NUM_KEYS;
    localparam key_vec_t       KEY_MASK    = KEY_W'(KEY_ONE_HOT - (KEY_W+1)'(1));

    key_vec_t prev_reg;
    key_vec_t prev_next;
    key_vec_t changed;
    logic     accept;

    assign key_stall = q_full;
    assign accept    = key_valid && !q_full;
    assign changed   = (prev_reg ^ key_state) & KEY_MASK;

    assign push                 = accept && (changed != '0);
    assign push_data.press_mask = changed & key_state;
    assign push_data.rel_mask   = changed & ~key_state;

    assign prev_next = accept ? key_state : prev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else
        begin
            prev_reg <= prev_next;
        end
    end

endmodule

>>> rtl/kceg_queue.sv
// Two-entry register queue between the front end and the event serializer.
// Depends on kceg_pkg.
module kceg_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  kceg_pkg::kceg_entry_t push_data,
    input  logic                  pop,
    output kceg_pkg::kceg_entry_t head,
    output logic                  full,
    output logic                  empty
);
    import kceg_pkg::*;

    kceg_entry_t              entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]       wr_ptr_reg;
    logic [Q_PTR_W-1:0]       wr_ptr_next;
    logic [Q_PTR_W-1:0]       rd_ptr_reg;
    logic [Q_PTR_W-1:0]       rd_ptr_next;
    logic [Q_CNT_W-1:0]       count_reg;
    logic [Q_CNT_W-1:0]       count_next;
    logic                     do_push;
    logic                     do_pop;

    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

endmodule

>>> rtl/kceg_back.sv
// Back end: serializes one queued change request into press then release events.
// Depends on kceg_pkg.
module kceg_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  kceg_pkg::kceg_entry_t head,
    input  logic                  q_empty,
    output logic                  pop,
    output logic                  event_valid,
    input  logic                  event_stall,
    output logic                  is_release,
    output kceg_pkg::key_idx_t    key_number,
    output logic                  last
);
    import kceg_pkg::*;

    key_vec_t press_reg;
    key_vec_t press_next;
    key_vec_t rel_reg;
    key_vec_t rel_next;
    logic     busy_reg;
    logic     busy_next;
    logic     out_valid_reg;
    logic     out_valid_next;
    logic     is_release_reg;
    logic     is_release_next;
    key_idx_t key_number_reg;
    key_idx_t key_number_next;
    logic     last_reg;
    logic     last_next;

    logic     out_ready;
    logic     load_evt;
    logic     use_press;
    key_vec_t cur_vec;
    key_vec_t cur_rest;
    key_vec_t press_rest;
    key_vec_t rel_rest;

    assign out_ready = !out_valid_reg || !event_stall;
    assign load_evt  = busy_reg && out_ready;
    assign pop       = !busy_reg && !q_empty;

    assign use_press  = (press_reg != '0);
    assign cur_vec    = use_press ? press_reg : rel_reg;
    assign cur_rest   = cur_vec & (cur_vec - KEY_W'(1));
    assign press_rest = use_press ? cur_rest : press_reg;
    assign rel_rest   = use_press ? rel_reg : cur_rest;

    always_comb
    begin
        press_next      = press_reg;
        rel_next        = rel_reg;
        busy_next       = busy_reg;
        out_valid_next  = out_valid_reg;
        is_release_next = is_release_reg;
        key_number_next = key_number_reg;
        last_next       = last_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (pop)
        begin
            press_next = head.press_mask;
            rel_next   = head.rel_mask;
            busy_next  = 1'b1;
        end
        else if (load_evt)
        begin
            out_valid_next  = 1'b1;
            is_release_next = !use_press;
            key_number_next = lowest_index(cur_vec);
            last_next       = (press_rest == '0) && (rel_rest == '0);
            press_next      = press_rest;
            rel_next        = rel_rest;
            busy_next       = !last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        press_reg      <= press_next;
        rel_reg        <= rel_next;
        is_release_reg <= is_release_next;
        key_number_reg <= key_number_next;
        last_reg       <= last_next;
    end

    assign event_valid = out_valid_reg;
    assign is_release  = is_release_reg;
    assign key_number  = key_number_reg;
    assign last        = last_reg;

    a_busy_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ((press_reg | rel_reg) != '0))
        else $error("serializer busy with empty masks");

    a_press_first: assert property (@(posedge clk) disable iff (!rst_n)
        (load_evt && use_press) |=> (out_valid_reg && !is_release_reg))
        else $error("release emitted while presses remain");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (load_evt && (press_rest == '0) && (rel_rest == '0)) |=> (last_reg && !busy_reg))
        else $error("final event not flagged or serializer still busy");

endmodule

>>> bench/tb.sv
// Testbench for key_change_event_generator: sends key vectors, predicts the
// press/release events of each one and checks every event that comes out.
// Depends on kceg_pkg and the key_change_event_generator RTL.
module tb;
    import kceg_pkg::*;

    localparam int NUM_KEYS     = 16;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 24;

    typedef struct packed {
        logic     is_release;
        key_idx_t key_number;
        logic     last;
    } key_event_t;

    logic       clk;
    logic       rst_n;
    key_vec_t   key_state;
    logic       key_valid;
    logic       key_stall;
    logic       event_valid;
    logic       event_stall;
    logic       is_release;
    key_idx_t   key_number;
    logic       last;

    key_vec_t   held_keys;
    key_event_t pending_events[$];
    int         errors;
    bit         idle_on;
    int         quiet_cycles;

    key_change_event_generator #(
        .NUM_KEYS(NUM_KEYS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .key_state(key_state),
        .key_valid(key_valid),
        .key_stall(key_stall),
        .event_valid(event_valid),
        .event_stall(event_stall),
        .is_release(is_release),
        .key_number(key_number),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Presses in ascending order, then releases; last on the final event.
    function automatic void predict_events(input key_vec_t now);
        key_vec_t   changed;
        key_event_t ev;
        key_event_t run[$];
        changed = held_keys ^ now;
        for (int pass = 0; pass < 2; pass++)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                if (changed[k] && (now[k] == (pass == 0)))
                begin
                    ev.is_release = (pass == 1);
                    ev.key_number = key_idx_t'(k);
                    ev.last       = 1'b0;
                    run.push_back(ev);
                end
            end
        end
        if (run.size() > 0)
        begin
            ev = run.pop_back();
            ev.last = 1'b1;
            run.push_back(ev);
        end
        foreach (run[i])
        begin
            pending_events.push_back(run[i]);
        end
        held_keys = now;
    endfunction

    task automatic send_keys(input key_vec_t v);
        bit taken;
        while (idle_on && $urandom_range(0, 99) < 33)
        begin
            key_valid <= 1'b0;
            @(posedge clk);
        end
        key_state <= v;
        key_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            taken = !key_stall;
            @(posedge clk);
        end while (!taken);
        predict_events(v);
    endtask

    task automatic wait_drained();
        key_valid <= 1'b0;
        while (pending_events.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_directed();
        key_vec_t vectors[$];
        vectors = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001, 16'h8000,
                    16'h8001, 16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0, 16'h0000,
                    16'h1234, 16'h1234, 16'h0000};
        foreach (vectors[i])
        begin
            send_keys(vectors[i]);
        end
        wait_drained();
    endtask

    // Sender holds off until all events are out, several times over.
    task automatic test_pause_between_samples();
        for (int i = 0; i < 6; i++)
        begin
            send_keys(key_vec_t'($urandom));
            wait_drained();
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        for (int i = 0; i < 40; i++)
        begin
            send_keys(key_vec_t'($urandom));
        end
        wait_drained();
        idle_on = 1'b1;
    endtask

    task automatic test_random_samples();
        key_vec_t v;
        for (int i = 0; i < 150; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: v = key_vec_t'($urandom);
                4, 5:       v = held_keys ^ (key_vec_t'(1) << $urandom_range(0, 15));
                6:          v = held_keys ^ key_vec_t'($urandom & $urandom);
                7:          v = held_keys;
                8:          v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                default:    v = ~held_keys;
            endcase
            send_keys(v);
        end
        wait_drained();
    endtask

    // Event checker and output stall generator.
    always
    begin : event_check
        key_event_t got;
        key_event_t want;
        bit         take;
        @(negedge clk);
        take = rst_n && event_valid && !event_stall;
        got  = '{is_release, key_number, last};
        @(posedge clk);
        if (take)
        begin
            if (pending_events.size() == 0)
            begin
                $error("unexpected event: is_release %0d key_number %0d last %0d",
                       got.is_release, got.key_number, got.last);
                errors++;
            end
            else
            begin
                want = pending_events.pop_front();
                if (got.is_release !== want.is_release)
                begin
                    $error("is_release: expected %0d, got %0d",
                           want.is_release, got.is_release);
                    errors++;
                end
                if (got.key_number !== want.key_number)
                begin
                    $error("key_number: expected %0d, got %0d",
                           want.key_number, got.key_number);
                    errors++;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    errors++;
                end
            end
        end
        event_stall <= idle_on && ($urandom_range(0, 99) < 33);
    end

    // Ends the run if neither channel moves for too long.
    always
    begin : watchdog
        @(negedge clk);
        if ((key_valid && !key_stall) || (event_valid && !event_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("key_change_event_generator verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        key_state    = '0;
        key_valid    = 1'b0;
        event_stall  = 1'b0;
        held_keys    = '0;
        errors       = 0;
        idle_on      = 1'b1;
        quiet_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_pause_between_samples();
        test_back_to_back();
        test_random_samples();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_events.size() != 0)
        begin
            $error("%0d expected events never arrived", pending_events.size());
            errors++;
        end
        if (errors == 0)
        begin
            $display("key_change_event_generator verification clean");
        end
        else
        begin
            $display("key_change_event_generator verification failed");
        end
        $finish;
    end
endmodule
